// File: hw/rtl/ghp_pkg.sv
package ghp_pkg;

	// Field widths fixed by the transaction format
	localparam int CMD_W    = 3;
	localparam int TASK_W   = 32;
	localparam int IDX_W    = 6;
	localparam int GEN_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_MARK     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIND     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RECLAIM  = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_STALE = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

	// One slot of the handle table
	typedef struct packed {
		logic [TASK_W-1:0] task_ref;
		logic [GEN_W-1:0]  gen;
		logic              launched;
		logic              done_mark;
	} slot_entry_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_HRD,
		S_HEX,
		S_SCRD,
		S_SCCHK,
		S_SCEND,
		S_POPRD,
		S_POPSL,
		S_POPWR
	} ghp_state_t;

endpackage

// File: hw/rtl/generational_handle_pool.sv
// Generational handle pool. Start a transaction by raising start while busy is low; the
// command and its fields are taken at that clock edge. The result appears for exactly one
// cycle with done high, and must be captured then: it is not held. An unknown command answers
// in the cycle after start with busy never raised. Mark, find and complete read the slot
// memory, then check the handle and, for mark and complete, write back. An insert that finds
// a free index reads the free stack, reads the slot, then writes the slot. A reclaim, and an
// insert that finds the free stack empty, walk the opened slots, reading each, then checking
// it and clearing it if it is finished; the insert then pops a reclaimed index if the walk
// freed one, or else opens the next unused slot or answers full. No clearing pass is needed
// after reset: only opened slots are ever used, as the index check discards a read of any
// other slot, and each slot is written when it is opened.
module generational_handle_pool
	import ghp_pkg::*;
#(
	parameter int SLOT_COUNT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [TASK_W-1:0]   task_ref,
	input  logic [IDX_W-1:0]    slot_index,
	input  logic [GEN_W-1:0]    handle_generation,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0]    out_index,
	output logic [GEN_W-1:0]    out_generation,
	output logic [TASK_W-1:0]   found_task,
	output logic [COUNT_W-1:0]  slots_in_use_count
);

	localparam int IW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW   = $clog2(SLOT_COUNT + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
	localparam logic [CW-1:0] SLOTS = CW'(SLOT_COUNT);

	// Memories
	slot_entry_t   slot_mem [SLOT_COUNT];
	logic [IW-1:0] fs_mem   [SLOT_COUNT];

	// Control state
	ghp_state_t    state_q, state_d;
	logic [CW-1:0] depth_q, depth_d;
	logic [CW-1:0] opened_q, opened_d;
	logic [CW-1:0] scan_q, scan_d;
	logic          done_q;

	// Transaction capture
	logic [CMD_W-1:0]  cmd_q;
	logic [TASK_W-1:0] task_q;
	logic [IDX_W-1:0]  idx_q;
	logic [GEN_W-1:0]  gen_q;

	// Memory read data
	slot_entry_t   sl_rd_q;
	logic [IW-1:0] fs_rd_q;

	// Result registers
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    oidx_q;
	logic [GEN_W-1:0]    ogen_q;
	logic [TASK_W-1:0]   found_q;

	// Datapath controls
	logic                accept;
	logic                sl_re, sl_we, fs_re, fs_we;
	logic [IW-1:0]       sl_raddr, sl_waddr, fs_raddr, fs_waddr, fs_wdata;
	slot_entry_t         sl_wdata;
	logic                res_load;
	logic [STATUS_W-1:0] res_status;
	logic [IDX_W-1:0]    res_index;
	logic [GEN_W-1:0]    res_gen;
	logic [TASK_W-1:0]   res_found;
	logic                handle_ok;
	logic                reclaimable;

	assign accept = start && (state_q == S_IDLE);

	assign handle_ok = (CMPW'(idx_q) < CMPW'(opened_q)) && (sl_rd_q.gen == gen_q);
	assign reclaimable = (sl_rd_q.task_ref != '0) && sl_rd_q.launched && sl_rd_q.done_mark;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					case (command) inside
						CMD_INSERT: begin
							if (depth_q != '0)
								state_d = S_POPRD;
							else if (opened_q != '0)
								state_d = S_SCRD;
							else
								state_d = S_SCEND;
						end
						CMD_MARK, CMD_FIND, CMD_COMPLETE: state_d = S_HRD;
						CMD_RECLAIM: state_d = (opened_q != '0) ? S_SCRD : S_SCEND;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_HRD:   state_d = S_HEX;
			S_HEX:   state_d = S_IDLE;
			S_SCRD:  state_d = S_SCCHK;
			S_SCCHK: state_d = (CW'(scan_q + 1'b1) == opened_q) ? S_SCEND : S_SCRD;
			S_SCEND: begin
				if (cmd_q == CMD_INSERT && depth_q != '0)
					state_d = S_POPRD;
				else
					state_d = S_IDLE;
			end
			S_POPRD: state_d = S_POPSL;
			S_POPSL: state_d = S_POPWR;
			S_POPWR: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath controls per state
	always_comb begin
		sl_re      = 1'b0;
		sl_raddr   = IW'(idx_q);
		sl_we      = 1'b0;
		sl_waddr   = IW'(idx_q);
		sl_wdata   = sl_rd_q;
		fs_re      = 1'b0;
		fs_raddr   = IW'(depth_q - 1'b1);
		fs_we      = 1'b0;
		fs_waddr   = depth_q[IW-1:0];
		fs_wdata   = scan_q[IW-1:0];
		depth_d    = depth_q;
		opened_d   = opened_q;
		scan_d     = scan_q;
		res_load   = 1'b0;
		res_status = STS_OK;
		res_index  = idx_q;
		res_gen    = '0;
		res_found  = '0;
		unique case (state_q)
			S_IDLE: begin
				scan_d = '0;
				// Answer an unknown command straight away
				if (start && command != CMD_INSERT && command != CMD_MARK &&
				    command != CMD_FIND && command != CMD_COMPLETE &&
				    command != CMD_RECLAIM) begin
					res_load   = 1'b1;
					res_status = STS_STALE;
					res_index  = slot_index;
				end
			end
			S_HRD: begin
				sl_re = 1'b1;
			end
			S_HEX: begin
				res_load   = 1'b1;
				res_status = handle_ok ? STS_OK : STS_STALE;
				res_gen    = handle_ok ? sl_rd_q.gen : '0;
				if (handle_ok && cmd_q == CMD_FIND)
					res_found = sl_rd_q.task_ref;
				if (handle_ok && cmd_q == CMD_MARK) begin
					sl_we             = 1'b1;
					sl_wdata.launched = 1'b1;
				end
				if (handle_ok && cmd_q == CMD_COMPLETE) begin
					sl_we              = 1'b1;
					sl_wdata.done_mark = 1'b1;
				end
			end
			S_SCRD: begin
				sl_re    = 1'b1;
				sl_raddr = scan_q[IW-1:0];
			end
			S_SCCHK: begin
				scan_d = CW'(scan_q + 1'b1);
				// Free a finished slot: clear it, bump its generation, push its index
				if (reclaimable) begin
					sl_we              = 1'b1;
					sl_waddr           = scan_q[IW-1:0];
					sl_wdata.task_ref  = '0;
					sl_wdata.gen       = sl_rd_q.gen + 1'b1;
					sl_wdata.launched  = 1'b0;
					sl_wdata.done_mark = 1'b0;
					if (depth_q < SLOTS) begin
						fs_we   = 1'b1;
						depth_d = CW'(depth_q + 1'b1);
					end
				end
			end
			S_SCEND: begin
				if (cmd_q == CMD_RECLAIM) begin
					res_load = 1'b1;
				end else if (depth_q == '0) begin
					res_load = 1'b1;
					if (opened_q < SLOTS) begin
						// Open the next unused slot; its generation is still zero
						sl_we              = 1'b1;
						sl_waddr           = opened_q[IW-1:0];
						sl_wdata.task_ref  = task_q;
						sl_wdata.gen       = '0;
						sl_wdata.launched  = 1'b0;
						sl_wdata.done_mark = 1'b0;
						opened_d           = CW'(opened_q + 1'b1);
						res_index          = IDX_W'(opened_q[IW-1:0]);
					end else begin
						res_status = STS_FULL;
						res_index  = '0;
					end
				end
			end
			S_POPRD: begin
				fs_re   = 1'b1;
				depth_d = CW'(depth_q - 1'b1);
			end
			S_POPSL: begin
				sl_re    = 1'b1;
				sl_raddr = fs_rd_q;
			end
			S_POPWR: begin
				sl_we              = 1'b1;
				sl_waddr           = fs_rd_q;
				sl_wdata.task_ref  = task_q;
				sl_wdata.launched  = 1'b0;
				sl_wdata.done_mark = 1'b0;
				res_load           = 1'b1;
				res_index          = IDX_W'(fs_rd_q);
				res_gen            = sl_rd_q.gen;
			end
			default: ;
		endcase
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			depth_q  <= '0;
			opened_q <= '0;
			scan_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			depth_q  <= depth_d;
			opened_q <= opened_d;
			scan_q   <= scan_d;
			done_q   <= res_load;
		end
	end

	// Capture the transaction and hold the result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= command;
			task_q <= task_ref;
			idx_q  <= slot_index;
			gen_q  <= handle_generation;
		end
		if (res_load) begin
			status_q <= res_status;
			oidx_q   <= res_index;
			ogen_q   <= res_gen;
			found_q  <= res_found;
		end
	end

	// Slot memory
	always_ff @(posedge clk) begin
		if (sl_we)
			slot_mem[sl_waddr] <= sl_wdata;
		if (sl_re)
			sl_rd_q <= slot_mem[sl_raddr];
	end

	// Free index stack
	always_ff @(posedge clk) begin
		if (fs_we)
			fs_mem[fs_waddr] <= fs_wdata;
		if (fs_re)
			fs_rd_q <= fs_mem[fs_raddr];
	end

	assign busy               = (state_q != S_IDLE);
	assign done               = done_q;
	assign status             = status_q;
	assign out_index          = oidx_q;
	assign out_generation     = ogen_q;
	assign found_task         = found_q;
	assign slots_in_use_count = COUNT_W'(opened_q);

`ifndef SYNTHESIS
	a_depth_le_opened: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= opened_q)
		else $error("free stack deeper than opened slots");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCRD || state_q == S_SCCHK) |-> scan_q < opened_q)
		else $error("reclaim scan beyond opened slots");

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy))
		else $error("result without a transaction");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STS_OK || status == STS_STALE || status == STS_FULL))
		else $error("illegal status code");
`endif

endmodule
